>>> rtl/slc_pkg.sv
// Shared package of the segment and line intersection block.
// Holds the fail codes, default sizes and the queue word width helper.
// Depends on nothing; every other file of the block but slc_fifo uses it.
`timescale 1ns / 1ps

package slc_pkg;

	// Default coordinate width of the signed fixed-point inputs and results.
	localparam int COORD_WIDTH_DEF = 32;

	// Depth of the queue between the front and the back end.
	localparam int QUEUE_DEPTH = 4;

	// Depth of the output buffer behind the back end.
	localparam int OUT_DEPTH = 2;

	// Outcome of one query.
	typedef enum logic [2:0] {
		FAIL_NONE     = 3'd0,
		FAIL_ZERO_LEN = 3'd1,
		FAIL_SHARED   = 3'd2,
		FAIL_NO_CROSS = 3'd3,
		FAIL_OUTSIDE  = 3'd4
	} fail_code_t;

	// Width of one queue word: code, numerator, denominator, direction of
	// the first segment and its start point.
	function automatic int queue_width(input int cw);
		return 3 + (2 * cw + 3) + (2 * cw + 4) + 2 * (cw + 1) + 2 * cw;
	endfunction

endpackage

>>> rtl/slc_in_if.sv
// Request channel of the intersection block: two segments and a mode.
// Depends on slc_pkg for the default coordinate width.
`timescale 1ns / 1ps

interface slc_in_if #(
	parameter int COORD_WIDTH = slc_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic signed [COORD_WIDTH-1:0] first_start_x;
	logic signed [COORD_WIDTH-1:0] first_start_y;
	logic signed [COORD_WIDTH-1:0] first_end_x;
	logic signed [COORD_WIDTH-1:0] first_end_y;
	logic signed [COORD_WIDTH-1:0] second_start_x;
	logic signed [COORD_WIDTH-1:0] second_start_y;
	logic signed [COORD_WIDTH-1:0] second_end_x;
	logic signed [COORD_WIDTH-1:0] second_end_y;

	modport source (
		output valid, mode, first_start_x, first_start_y, first_end_x, first_end_y,
		       second_start_x, second_start_y, second_end_x, second_end_y,
		input  ready
	);

	modport sink (
		input  valid, mode, first_start_x, first_start_y, first_end_x, first_end_y,
		       second_start_x, second_start_y, second_end_x, second_end_y,
		output ready
	);
endinterface

>>> rtl/slc_out_if.sv
// Result channel of the intersection block: hit flag, fail code and point.
// Depends on slc_pkg for the fail code type and the default width.
`timescale 1ns / 1ps

interface slc_out_if #(
	parameter int COORD_WIDTH = slc_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	slc_pkg::fail_code_t           fail_code;
	logic signed [COORD_WIDTH-1:0] meet_x;
	logic signed [COORD_WIDTH-1:0] meet_y;

	modport source (
		output valid, hit, fail_code, meet_x, meet_y,
		input  ready
	);

	modport sink (
		input  valid, hit, fail_code, meet_x, meet_y,
		output ready
	);
endinterface

>>> rtl/slc_fifo.sv
// Small register FIFO used as the front-to-back queue and the output buffer.
// Depends on nothing outside itself.
`timescale 1ns / 1ps

module slc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             not_empty
);
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q;
	logic [PTRW-1:0]  rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign full      = (count_q == CNTW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

>>> rtl/slc_front.sv
// Front end: accepts queries, forms the cross products and classifies them.
// Depends on slc_pkg and slc_in_if; feeds the queue in front of slc_back.
`timescale 1ns / 1ps

module slc_front #(
	parameter int COORD_WIDTH = slc_pkg::COORD_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	slc_in_if.sink                                        req,
	input  logic                                          q_full,
	output logic                                          push,
	output logic [slc_pkg::queue_width(COORD_WIDTH)-1:0] push_data
);
	import slc_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int DW   = CW + 1;
	localparam int PW   = 2 * DW;
	localparam int XW   = PW + 1;
	localparam int DENW = XW + 1;

	logic en;
	logic zero_len;
	logic shared_end;

	logic v_s1, v_s2, v_s3;

	logic                 mode_s1, mode_s2, mode_s3;
	fail_code_t           code_s1, code_s2, code_s3;
	logic signed [CW-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic signed [DW-1:0] ux_s1, uy_s1, px_s1, py_s1, qx_s1, qy_s1;
	logic signed [DW-1:0] ux_s2, uy_s2, ux_s3, uy_s3;
	logic signed [PW-1:0] m_upy_s2, m_upx_s2, m_uqy_s2, m_uqx_s2, m_pqy_s2, m_pqx_s2;
	logic signed [XW-1:0] sc_s3, sd_s3, num_s3;

	logic signed [DENW-1:0] den;
	logic signed [DENW-1:0] num_ext;
	fail_code_t             code_fin;

	// The whole front advances while the queue has room.
	assign en        = !q_full;
	assign req.ready = en;

	// Degenerate inputs are recognised straight from the request fields.
	assign zero_len = ((req.first_start_x == req.first_end_x) &&
	                   (req.first_start_y == req.first_end_y)) ||
	                  ((req.second_start_x == req.second_end_x) &&
	                   (req.second_start_y == req.second_end_y));
	assign shared_end = !req.mode && (
		((req.first_start_x == req.second_start_x) && (req.first_start_y == req.second_start_y)) ||
		((req.first_end_x == req.second_start_x) && (req.first_end_y == req.second_start_y)) ||
		((req.first_start_x == req.second_end_x) && (req.first_start_y == req.second_end_y)) ||
		((req.first_end_x == req.second_end_x) && (req.first_end_y == req.second_end_y)));

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: differences relative to point A and the early codes.
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= req.mode;
			code_s1 <= zero_len ? FAIL_ZERO_LEN : (shared_end ? FAIL_SHARED : FAIL_NONE);
			ax_s1   <= req.first_start_x;
			ay_s1   <= req.first_start_y;
			ux_s1   <= DW'(req.first_end_x) - DW'(req.first_start_x);
			uy_s1   <= DW'(req.first_end_y) - DW'(req.first_start_y);
			px_s1   <= DW'(req.second_start_x) - DW'(req.first_start_x);
			py_s1   <= DW'(req.second_start_y) - DW'(req.first_start_y);
			qx_s1   <= DW'(req.second_end_x) - DW'(req.first_start_x);
			qy_s1   <= DW'(req.second_end_y) - DW'(req.first_start_y);
		end
	end

	// Stage 2: the six products of the three cross products.
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2  <= mode_s1;
			code_s2  <= code_s1;
			ax_s2    <= ax_s1;
			ay_s2    <= ay_s1;
			ux_s2    <= ux_s1;
			uy_s2    <= uy_s1;
			m_upy_s2 <= ux_s1 * py_s1;
			m_upx_s2 <= uy_s1 * px_s1;
			m_uqy_s2 <= ux_s1 * qy_s1;
			m_uqx_s2 <= uy_s1 * qx_s1;
			m_pqy_s2 <= px_s1 * qy_s1;
			m_pqx_s2 <= py_s1 * qx_s1;
		end
	end

	// Stage 3: side values of C and D against AB, and the numerator of t.
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3 <= mode_s2;
			code_s3 <= code_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			ux_s3   <= ux_s2;
			uy_s3   <= uy_s2;
			sc_s3   <= XW'(m_upy_s2) - XW'(m_upx_s2);
			sd_s3   <= XW'(m_uqy_s2) - XW'(m_uqx_s2);
			num_s3  <= XW'(m_pqy_s2) - XW'(m_pqx_s2);
		end
	end

	// Denominator of t and the final classification.
	assign den     = DENW'(sd_s3) - DENW'(sc_s3);
	assign num_ext = DENW'(num_s3);

	always_comb begin
		code_fin = code_s3;
		if (code_s3 == FAIL_NONE) begin
			if (!mode_s3) begin
				if (sc_s3[XW-1] == sd_s3[XW-1]) begin
					code_fin = FAIL_NO_CROSS;
				end else if (!den[DENW-1]) begin
					if (num_s3[XW-1] || (num_ext > den)) begin
						code_fin = FAIL_OUTSIDE;
					end
				end else begin
					if ((!num_s3[XW-1] && (num_s3 != '0)) || (num_ext < den)) begin
						code_fin = FAIL_OUTSIDE;
					end
				end
			end else if (den == '0) begin
				code_fin = FAIL_NO_CROSS;
			end
		end
	end

	// Hand the classified transaction to the queue.
	assign push      = en && v_s3;
	assign push_data = {code_fin, num_s3, den, ux_s3, uy_s3, ax_s3, ay_s3};
endmodule

>>> rtl/slc_back.sv
// Back end: scales the first segment by t with a pipelined divider,
// rounds, adds the start point and saturates.
// Depends on slc_pkg; takes transactions from the queue behind slc_front.
`timescale 1ns / 1ps

module slc_back #(
	parameter int COORD_WIDTH = slc_pkg::COORD_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	input  logic [slc_pkg::queue_width(COORD_WIDTH)-1:0] in_data,
	output logic                                          pop,
	input  logic                                          out_full,
	output logic                                          push,
	output logic [2*COORD_WIDTH+3:0]                      push_data
);
	import slc_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int DW   = CW + 1;
	localparam int XW   = 2 * DW + 1;
	localparam int DENW = XW + 1;
	localparam int MW   = XW + DW;
	localparam int NW   = MW + 2;
	localparam int LB   = CW + 2;
	localparam int HB   = XW - LB;
	localparam int PLW  = LB + 1 + DW;
	localparam int PHW  = HB + DW;
	localparam int SW   = CW + 2;

	typedef struct packed {
		fail_code_t           code;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic                 negx;
		logic                 negy;
		logic                 ovfx;
		logic                 ovfy;
	} ctx_t;

	logic en;

	logic [2:0]             in_code;
	logic signed [XW-1:0]   in_num;
	logic signed [DENW-1:0] in_den;
	logic signed [DW-1:0]   in_ux, in_uy;
	logic signed [CW-1:0]   in_ax, in_ay;
	ctx_t                   in_ctx;
	ctx_t                   ctx_sign;
	ctx_t                   ctx_ovf;

	logic v_s1, v_s2, v_s3, v_s4, v_sf;
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_sf;

	logic signed [PLW-1:0]  plx_s1, ply_s1;
	logic signed [PHW-1:0]  phx_s1, phy_s1;
	logic signed [DENW-1:0] den_s1, den_s2;
	logic signed [MW-1:0]   prodx_s2, prody_s2;
	logic [MW-1:0]          anx_s3, any_s3;
	logic [DENW-1:0]        ad_s3;
	logic [NW-1:0]          nx_s4, ny_s4, dd_s4;

	logic [CW:0]   v_sd;
	ctx_t          ctx_sd   [CW+1];
	logic [NW-1:0] remx_sd  [CW+1];
	logic [NW-1:0] remy_sd  [CW+1];
	logic [NW-1:0] dd_sd    [CW+1];
	logic [CW-1:0] qx_sd    [CW+1];
	logic [CW-1:0] qy_sd    [CW+1];

	logic signed [SW-1:0] sumx_sf, sumy_sf;
	logic signed [SW-1:0] offx, offy;
	logic signed [CW-1:0] meet_x, meet_y;

	// Clamp a widened sum, or pick the end of the range on quotient overflow.
	function automatic logic [CW-1:0] saturate(input logic [SW-1:0] sum, input logic ovf,
	                                           input logic neg);
		logic [CW-1:0] max_v;
		logic [CW-1:0] min_v;
		logic [CW-1:0] res;
		max_v = {1'b0, {(CW-1){1'b1}}};
		min_v = {1'b1, {(CW-1){1'b0}}};
		if (ovf) begin
			res = neg ? min_v : max_v;
		end else if ((sum[SW-1:CW-1] != '0) && (sum[SW-1:CW-1] != '1)) begin
			res = sum[SW-1] ? min_v : max_v;
		end else begin
			res = sum[CW-1:0];
		end
		return res;
	endfunction

	// The back end advances while the output buffer has room.
	assign en  = !out_full;
	assign pop = en && in_valid;

	assign {in_code, in_num, in_den, in_ux, in_uy, in_ax, in_ay} = in_data;

	always_comb begin
		in_ctx      = '0;
		in_ctx.code = fail_code_t'(in_code);
		in_ctx.ax   = in_ax;
		in_ctx.ay   = in_ay;
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_sd[0] <= 1'b0;
			v_sf    <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_sd[0] <= v_s4;
			v_sf    <= v_sd[CW];
		end
	end

	// Stage 1: partial products of the numerator with the direction of AB.
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= in_ctx;
			den_s1 <= in_den;
			plx_s1 <= $signed({1'b0, in_num[LB-1:0]}) * in_ux;
			ply_s1 <= $signed({1'b0, in_num[LB-1:0]}) * in_uy;
			phx_s1 <= $signed(in_num[XW-1:LB]) * in_ux;
			phy_s1 <= $signed(in_num[XW-1:LB]) * in_uy;
		end
	end

	// Stage 2: partial products summed to the full product.
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2   <= ctx_s1;
			den_s2   <= den_s1;
			prodx_s2 <= $signed({phx_s1, {LB{1'b0}}}) + MW'(plx_s1);
			prody_s2 <= $signed({phy_s1, {LB{1'b0}}}) + MW'(ply_s1);
		end
	end

	// Sign of each quotient joins the context ahead of stage 3.
	always_comb begin
		ctx_sign      = ctx_s2;
		ctx_sign.negx = prodx_s2[MW-1] ^ den_s2[DENW-1];
		ctx_sign.negy = prody_s2[MW-1] ^ den_s2[DENW-1];
	end

	// Stage 3: magnitudes and the sign of each quotient.
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3 <= ctx_sign;
			anx_s3 <= prodx_s2[MW-1] ? MW'(-prodx_s2) : MW'(prodx_s2);
			any_s3 <= prody_s2[MW-1] ? MW'(-prody_s2) : MW'(prody_s2);
			ad_s3  <= den_s2[DENW-1] ? DENW'(-den_s2) : DENW'(den_s2);
		end
	end

	// Stage 4: rounding is folded in as (2|n| + |d|) / (2|d|).
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= ctx_s3;
			nx_s4  <= {1'b0, anx_s3, 1'b0} + NW'(ad_s3);
			ny_s4  <= {1'b0, any_s3, 1'b0} + NW'(ad_s3);
			dd_s4  <= NW'({ad_s3, 1'b0});
		end
	end

	// A quotient that needs more than CW bits always saturates.
	always_comb begin
		ctx_ovf      = ctx_s4;
		ctx_ovf.ovfx = (nx_s4 >= (dd_s4 << CW));
		ctx_ovf.ovfy = (ny_s4 >= (dd_s4 << CW));
	end

	// Stage 5: entry of the divider.
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_sd[0]  <= ctx_ovf;
			remx_sd[0] <= nx_s4;
			remy_sd[0] <= ny_s4;
			dd_sd[0]   <= dd_s4;
			qx_sd[0]   <= '0;
			qy_sd[0]   <= '0;
		end
	end

	// Restoring divider: one quotient bit per stage, most significant first.
	for (genvar k = 0; k < CW; k++) begin : g_div
		localparam int SH = CW - 1 - k;

		logic [NW:0] trx;
		logic [NW:0] trl;

		assign trx = {1'b0, remx_sd[k]} - {1'b0, (dd_sd[k] << SH)};
		assign trl = {1'b0, remy_sd[k]} - {1'b0, (dd_sd[k] << SH)};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (en) begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_sd[k+1]  <= ctx_sd[k];
				dd_sd[k+1]   <= dd_sd[k];
				remx_sd[k+1] <= trx[NW] ? remx_sd[k] : trx[NW-1:0];
				remy_sd[k+1] <= trl[NW] ? remy_sd[k] : trl[NW-1:0];
				qx_sd[k+1]   <= qx_sd[k] | (trx[NW] ? '0 : (CW'(1) << SH));
				qy_sd[k+1]   <= qy_sd[k] | (trl[NW] ? '0 : (CW'(1) << SH));
			end
		end
	end

	// Final stage: signed offset added to the start point.
	assign offx = ctx_sd[CW].negx ? (SW'(0) - $signed(SW'(qx_sd[CW]))) : $signed(SW'(qx_sd[CW]));
	assign offy = ctx_sd[CW].negy ? (SW'(0) - $signed(SW'(qy_sd[CW]))) : $signed(SW'(qy_sd[CW]));

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_sf  <= ctx_sd[CW];
			sumx_sf <= SW'(ctx_sd[CW].ax) + offx;
			sumy_sf <= SW'(ctx_sd[CW].ay) + offy;
		end
	end

	// Result word: failures carry a zero point.
	assign meet_x = (ctx_sf.code != FAIL_NONE) ? '0 :
	                saturate(sumx_sf, ctx_sf.ovfx, ctx_sf.negx);
	assign meet_y = (ctx_sf.code != FAIL_NONE) ? '0 :
	                saturate(sumy_sf, ctx_sf.ovfy, ctx_sf.negy);

	assign push      = en && v_sf;
	assign push_data = {(ctx_sf.code == FAIL_NONE), ctx_sf.code, meet_x, meet_y};
endmodule

>>> rtl/segment_line_intersection.sv
// Top level of the two-dimensional segment and line intersection block.
// Depends on slc_pkg, slc_in_if, slc_out_if, slc_fifo, slc_front, slc_back.
//
//   channel | modport | contents
//   req     | sink    | mode, points A, B, C, D (signed fixed point)
//   rsp     | source  | hit, fail_code, meet_x, meet_y
//
// One transaction per clock cycle is accepted and delivered in steady flow.
// The divider takes one quotient bit per stage and sets most of the latency
// from request to response. Reset clears all valid bits and FIFO levels;
// payload is not reset. The front stalls only while the queue is full, the
// back only while the two-entry output buffer is full; neither sees the
// other's stall directly.
`timescale 1ns / 1ps

module segment_line_intersection #(
	parameter int COORD_WIDTH = slc_pkg::COORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	slc_in_if.sink    req,
	slc_out_if.source rsp
);
	import slc_pkg::*;

	localparam int QW = queue_width(COORD_WIDTH);
	localparam int OW = 2 * COORD_WIDTH + 4;

	logic          q_push, q_pop, q_full, q_not_empty;
	logic [QW-1:0] q_push_data, q_pop_data;

	logic          o_push, o_pop, o_full, o_not_empty;
	logic [OW-1:0] o_push_data, o_pop_data;
	logic [2:0]    o_code;

	// Classification front end.
	slc_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_full   (q_full),
		.push     (q_push),
		.push_data(q_push_data)
	);

	// Queue between front and back.
	slc_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.full     (q_full),
		.not_empty(q_not_empty)
	);

	// Division and point reconstruction.
	slc_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_not_empty),
		.in_data  (q_pop_data),
		.pop      (q_pop),
		.out_full (o_full),
		.push     (o_push),
		.push_data(o_push_data)
	);

	// Output buffer decouples the result channel from the back end.
	slc_fifo #(
		.WIDTH(OW),
		.DEPTH(OUT_DEPTH)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (o_push),
		.push_data(o_push_data),
		.pop      (o_pop),
		.pop_data (o_pop_data),
		.full     (o_full),
		.not_empty(o_not_empty)
	);

	// Result channel.
	assign o_pop     = o_not_empty && rsp.ready;
	assign rsp.valid = o_not_empty;
	assign {rsp.hit, o_code, rsp.meet_x, rsp.meet_y} = o_pop_data;
	assign rsp.fail_code = fail_code_t'(o_code);
endmodule

>>> tb/segment_line_intersection_tb.sv
// Self-checking testbench of the segment and line intersection block.
// Depends on slc_pkg, slc_in_if, slc_out_if and segment_line_intersection.
// A wide-integer predictor forecasts every response; a scoreboard checks them in order.
`timescale 1ns / 1ps

// Holds the expected responses of pending queries and predicts the response of the block exactly.
class intersection_scoreboard;
	typedef struct packed {
		logic                hit;
		slc_pkg::fail_code_t code;
		logic signed [31:0]  mx;
		logic signed [31:0]  my;
	} answer_t;

	answer_t pending[$];
	int      errors;

	// Rounded quotient, ties away from zero.
	static function automatic logic signed [255:0] round_div(
		input logic signed [255:0] n, input logic signed [255:0] d);
		logic signed [255:0] an, ad, q;
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		q = (2 * an + ad) / (2 * ad);
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	static function automatic logic signed [31:0] clamp32(input logic signed [255:0] v);
		if (v > 256'sd2147483647) return 32'sh7fffffff;
		if (v < -256'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Works out the expected response to one accepted query.
	function void note_query(input logic line_mode, input logic signed [31:0] c[8]);
		logic signed [255:0] ax, ay, bx, by, cx, cy, dx, dy;
		logic signed [255:0] ux, uy, px, py, qx, qy, sc, sd, den, num;
		answer_t a;
		ax = c[0]; ay = c[1]; bx = c[2]; by = c[3];
		cx = c[4]; cy = c[5]; dx = c[6]; dy = c[7];
		a = '{1'b0, slc_pkg::FAIL_NONE, 32'sd0, 32'sd0};
		if ((ax == bx && ay == by) || (cx == dx && cy == dy))
			a.code = slc_pkg::FAIL_ZERO_LEN;
		else if (!line_mode && ((ax == cx && ay == cy) || (bx == cx && by == cy) ||
				(ax == dx && ay == dy) || (bx == dx && by == dy)))
			a.code = slc_pkg::FAIL_SHARED;
		if (a.code == slc_pkg::FAIL_NONE) begin
			ux = bx - ax; uy = by - ay;
			px = cx - ax; py = cy - ay;
			qx = dx - ax; qy = dy - ay;
			sc = ux * py - uy * px;
			sd = ux * qy - uy * qx;
			den = sd - sc;
			num = px * qy - py * qx;
			if (!line_mode) begin
				if ((sc < 0) == (sd < 0))
					a.code = slc_pkg::FAIL_NO_CROSS;
				else if (den >= 0) begin
					if (num < 0 || num > den) a.code = slc_pkg::FAIL_OUTSIDE;
				end else begin
					if (num > 0 || num < den) a.code = slc_pkg::FAIL_OUTSIDE;
				end
			end else if (den == 0) begin
				a.code = slc_pkg::FAIL_NO_CROSS;
			end
			if (a.code == slc_pkg::FAIL_NONE) begin
				a.hit = 1'b1;
				a.mx = clamp32(ax + round_div(num * ux, den));
				a.my = clamp32(ay + round_div(num * uy, den));
			end
		end
		pending.insert(pending.size(), a);
	endfunction

	// Compares one delivered response with the oldest expectation.
	function void check_response(input answer_t got);
		answer_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected response %p", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.hit !== want.hit) begin
			$display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
			errors++;
		end
		if (got.code !== want.code) begin
			$display("%0t: fail_code expected %0d actual %0d", $time, want.code, got.code);
			errors++;
		end
		if (got.mx !== want.mx) begin
			$display("%0t: meet_x expected %0d actual %0d", $time, want.mx, got.mx);
			errors++;
		end
		if (got.my !== want.my) begin
			$display("%0t: meet_y expected %0d actual %0d", $time, want.my, got.my);
			errors++;
		end
	endfunction
endclass

module segment_line_intersection_tb;
	import slc_pkg::*;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;

	slc_in_if  req ();
	slc_out_if rsp ();

	intersection_scoreboard board;

	segment_line_intersection u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Safety limit on the run time.
	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

	// Random stalls on the response side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Checks every response transaction.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_response({rsp.hit, rsp.fail_code, rsp.meet_x, rsp.meet_y});
	end

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $signed($urandom_range(65535)) - 32768;
			2: return 32'sh7fffffff - $urandom_range(3);
			3: return 32'sh80000000 + $urandom_range(3);
			default: return ($signed($urandom_range(2000)) - 1000) <<< 16;
		endcase
	endfunction

	// Sends one query, holding it until the block accepts it.
	task automatic send_query(input logic line_mode, input logic signed [31:0] c[8]);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid          <= 1'b1;
		req.mode           <= line_mode;
		req.first_start_x  <= c[0];
		req.first_start_y  <= c[1];
		req.first_end_x    <= c[2];
		req.first_end_y    <= c[3];
		req.second_start_x <= c[4];
		req.second_start_y <= c[5];
		req.second_end_x   <= c[6];
		req.second_end_y   <= c[7];
		do @(posedge clk); while (!req.ready);
		board.note_query(line_mode, c);
	endtask

	// Random query; half are crossing pairs so that hits are frequent.
	task automatic send_random();
		logic signed [31:0] c[8];
		int pick;
		foreach (c[i]) c[i] = rand_coord();
		pick = $urandom_range(9);
		if (pick < 5) begin
			// C and D placed either side of A-B around a point on it.
			c[4] = c[0] + ($signed($urandom_range(2000)) - 1000) * 1024;
			c[5] = c[1] + ($signed($urandom_range(2000)) - 1000) * 1024;
			c[6] = c[0] + c[2] - c[4];
			c[7] = c[1] + c[3] - c[5];
		end else if (pick == 5) begin
			c[$urandom_range(1) ? 6 : 4] = c[$urandom_range(1) ? 0 : 2];
			c[7] = c[3]; c[6] = c[2];
		end else if (pick == 6) begin
			c[6] = c[4] + (c[2] - c[0]);
			c[7] = c[5] + (c[3] - c[1]);
		end
		send_query(1'($urandom_range(1)), c);
	endtask

	task automatic wait_drained();
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// Directed cases then three random phases with different stall mixes.
	initial begin
		logic signed [31:0] c[8];
		board = new();
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.mode = 1'b0;
		req.first_start_x = '0; req.first_start_y = '0;
		req.first_end_x = '0; req.first_end_y = '0;
		req.second_start_x = '0; req.second_start_y = '0;
		req.second_end_x = '0; req.second_end_y = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Simple crossing in both modes.
		c = '{0, 0, 32'sh20000, 32'sh20000, 0, 32'sh20000, 32'sh20000, 0};
		send_query(1'b0, c); send_query(1'b1, c);
		// Zero-length first, then second segment.
		c = '{5, 5, 5, 5, 0, 0, 9, 9};
		send_query(1'b0, c); send_query(1'b1, c);
		c = '{0, 0, 9, 9, 3, 3, 3, 3};
		send_query(1'b1, c);
		// Shared endpoint in segment mode, allowed in line mode.
		c = '{0, 0, 32'sh10000, 0, 32'sh10000, 0, 0, 32'sh10000};
		send_query(1'b0, c); send_query(1'b1, c);
		// Both on one side, and C touching A-B (zero side value).
		c = '{0, 0, 32'sh40000, 0, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh30000};
		send_query(1'b0, c);
		c = '{0, 0, 32'sh40000, 0, 32'sh10000, 0, 32'sh20000, -32'sh10000};
		send_query(1'b0, c);
		c = '{0, 0, 32'sh40000, 0, 32'sh10000, 32'sh10000, 32'sh20000, -32'sh10000};
		send_query(1'b0, c);
		// Crossing beyond B, and exactly at the ends of A-B.
		c = '{0, 0, 32'sh10000, 0, 32'sh30000, 32'sh10000, 32'sh30000, -32'sh10000};
		send_query(1'b0, c); send_query(1'b1, c);
		c = '{0, 0, 32'sh10000, 0, 32'sh10000, 32'sh10000, 32'sh10000, -32'sh10000};
		send_query(1'b0, c);
		c = '{0, 0, 32'sh10000, 0, 0, -32'sh10000, 0, 32'sh10000};
		send_query(1'b0, c);
		// Parallel lines.
		c = '{0, 0, 32'sh10000, 32'sh10000, 0, 32'sh10000, 32'sh10000, 32'sh20000};
		send_query(1'b1, c);
		// Extremes: saturation and rounding ties.
		c = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff};
		send_query(1'b0, c); send_query(1'b1, c);
		c = '{0, 0, 1, 0, 32'sh7ffffff0, 1, 32'sh7ffffff0, 2};
		send_query(1'b1, c);
		c = '{0, 0, 3, 1, 1, 0, 1, 1};
		send_query(1'b1, c);
		c = '{-1, -1, 2, 0, 0, 32'sh80000000, 1, 32'sh80000001};
		send_query(1'b1, c);
		c = '{32'shffffffff, 32'shffffffff, 32'sh7fffffff, 1, 0, 32'sh7fffffff, 2, -7};
		send_query(1'b0, c); send_query(1'b1, c);

		send_idle_pct = 17; recv_idle_pct = 80;
		repeat (180) send_random();
		send_idle_pct = 80; recv_idle_pct = 17;
		repeat (180) send_random();
		send_idle_pct = 0; recv_idle_pct = 0;
		repeat (190) send_random();
		req.valid <= 1'b0;
		wait_drained();
		repeat (60) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
